// ----- design/rrt_pkg.sv -----
// ---------------------------------------------------------------------------
// rrt_pkg - register range table shared types
// Record layout, result status codes and sequencer states.
// ---------------------------------------------------------------------------
package rrt_pkg;

   localparam int unsigned REG_W  = 8;
   localparam int unsigned SIZE_W = 8;
   localparam int unsigned VER_W  = 16;

   localparam int unsigned REQ_DATA_W = 32;
   localparam int unsigned REQ_USER_W = 2;
   localparam int unsigned RSP_DATA_W = 56;
   localparam int unsigned RSP_USER_W = 3;

   typedef enum logic [2:0] {
      ST_EXTENDED = 3'd0,
      ST_INSERTED = 3'd1,
      ST_IGNORED  = 3'd2,
      ST_FULL     = 3'd3,
      ST_CLEARED  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic [REG_W-1:0]  reg_id;
      logic [SIZE_W-1:0] size;
      logic [VER_W-1:0]  first_version;
      logic [VER_W-1:0]  last_version;
   } record_type;

   // request tdata layout, highest field first: version, access_size, reg_id
   typedef struct packed {
      logic [VER_W-1:0]  version;
      logic [SIZE_W-1:0] access_size;
      logic [REG_W-1:0]  reg_id;
   } item_type;

endpackage

// ----- design/register_range_table.sv -----
// ---------------------------------------------------------------------------
// register_range_table - per-expression register record table
// Tracks widest access size and version range for each register named in
// an expression; records are searched in insertion order.
// ---------------------------------------------------------------------------
//
//  channel | dir | tdata                                  | tuser
//  --------+-----+----------------------------------------+------------------
//  req_    | in  | reg_id, access_size, version           | op, is_register_ref
//  rsp_    | out | entry_index, size, first, last, count  | status
//
// Steps: a clear, a non-register node or an insert into an empty table passes
// through accept and emit; a register reference also compares records between
// the two, n being the records compared (1..count). One record is
// compared per cycle through the single read port of the record memory.
// Reset clears the record count and control state; the record memory is not
// cleared. The next transaction is accepted once the result sits in the
// output register, even while the output stalls.
// ---------------------------------------------------------------------------
module register_range_table #(
   parameter int unsigned ENTRIES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] reg_id, [15:8] access_size, [31:16] version
   input  logic [rrt_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] op, [1] is_register_ref
   input  logic [rrt_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [3:0] entry_index, [11:4] entry_size, [27:12] entry_first_version,
   // [43:28] entry_last_version, [48:44] entry_count, [55:49] zero
   output logic [rrt_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [2:0] status
   output logic [rrt_pkg::RSP_USER_W-1:0]    rsp_tuser
);
   import rrt_pkg::*;

   localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CW = $clog2(ENTRIES + 1);

   record_type mem [ENTRIES];

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [IW-1:0]    ptr_ff, ptr_in;
   logic [IW-1:0]    cmp_ff, cmp_in;
   item_type         item_ff, item_in;
   record_type       rd_data_ff;
   logic [IW-1:0]    rd_addr;

   status_type       res_status_ff, res_status_in;
   logic [IW-1:0]    res_index_ff, res_index_in;
   logic [SIZE_W-1:0] res_size_ff, res_size_in;
   logic [VER_W-1:0] res_first_ff, res_first_in;
   logic [VER_W-1:0] res_last_ff, res_last_in;

   logic                   rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0]  rsp_tdata_ff;
   logic [RSP_USER_W-1:0]  rsp_tuser_ff;

   logic        wr_en;
   logic [IW-1:0] wr_addr;
   record_type  wr_data;

   logic        req_fire;
   logic        req_op;
   logic        req_is_ref;
   item_type    req_item;
   logic        hit;
   logic        last_cmp;
   logic        out_free;
   record_type  merged;

   assign req_item   = req_tdata;
   assign req_op     = req_tuser[0];
   assign req_is_ref = req_tuser[1];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   assign hit      = (state_ff == S_SEARCH) && (rd_data_ff.reg_id == item_ff.reg_id);
   assign last_cmp = ((CW'(cmp_ff) + CW'(1)) == count_ff);

   always_comb begin
      merged = rd_data_ff;
      if (rd_data_ff.size < item_ff.access_size) begin
         merged.size = item_ff.access_size;
      end
      if (item_ff.version < rd_data_ff.first_version) begin
         merged.first_version = item_ff.version;
      end
      if (item_ff.version > rd_data_ff.last_version) begin
         merged.last_version = item_ff.version;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (!req_op || !req_is_ref || (count_ff == '0)) begin
                  state_in = S_EMIT;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            if (hit || last_cmp) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      cmp_in        = cmp_ff;
      item_in       = item_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_size_in   = res_size_ff;
      res_first_in  = res_first_ff;
      res_last_in   = res_last_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[IW-1:0];
      wr_data       = '{reg_id: item_ff.reg_id, size: item_ff.access_size,
                        first_version: item_ff.version, last_version: item_ff.version};
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               item_in       = req_item;
               ptr_in        = IW'(1);
               cmp_in        = '0;
               res_index_in  = '0;
               res_size_in   = '0;
               res_first_in  = '0;
               res_last_in   = '0;
               if (!req_op) begin
                  count_in      = '0;
                  res_status_in = ST_CLEARED;
               end else if (!req_is_ref) begin
                  res_status_in = ST_IGNORED;
               end else if (count_ff == '0) begin
                  // empty table: append straight away
                  wr_en         = 1'b1;
                  wr_addr       = '0;
                  wr_data       = '{reg_id: req_item.reg_id, size: req_item.access_size,
                                    first_version: req_item.version,
                                    last_version: req_item.version};
                  count_in      = CW'(1);
                  res_status_in = ST_INSERTED;
                  res_size_in   = req_item.access_size;
                  res_first_in  = req_item.version;
                  res_last_in   = req_item.version;
               end
            end
         end
         S_SEARCH: begin
            if (hit) begin
               wr_en         = 1'b1;
               wr_addr       = cmp_ff;
               wr_data       = merged;
               res_status_in = ST_EXTENDED;
               res_index_in  = cmp_ff;
               res_size_in   = merged.size;
               res_first_in  = merged.first_version;
               res_last_in   = merged.last_version;
            end else if (last_cmp) begin
               if (count_ff >= CW'(ENTRIES)) begin
                  count_in      = '0;
                  res_status_in = ST_FULL;
               end else begin
                  wr_en         = 1'b1;
                  count_in      = count_ff + CW'(1);
                  res_status_in = ST_INSERTED;
                  res_index_in  = count_ff[IW-1:0];
                  res_size_in   = item_ff.access_size;
                  res_first_in  = item_ff.version;
                  res_last_in   = item_ff.version;
               end
            end else begin
               // advance to the next record
               cmp_in = ptr_ff;
               ptr_in = ptr_ff + IW'(1);
            end
         end
         default: ;
      endcase
   end

   assign rd_addr = (state_ff == S_IDLE) ? '0 : ptr_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      cmp_ff        <= cmp_in;
      item_ff       <= item_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_size_ff   <= res_size_in;
      res_first_ff  <= res_first_in;
      res_last_ff   <= res_last_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (state_ff == S_EMIT && out_free) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_EMIT && out_free) begin
         rsp_tdata_ff <= {7'd0, 5'(count_ff), res_last_ff, res_first_ff, res_size_ff,
                          4'(res_index_ff)};
         rsp_tuser_ff <= res_status_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ENTRIES))
      else $error("record count beyond table depth");

   a_cmp_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> (CW'(cmp_ff) < count_ff))
      else $error("compare index outside filled records");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_op) |=> (count_ff == '0))
      else $error("clear did not empty the table");

   a_insert_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_INSERTED) |-> (rsp_tdata[27:12] == rsp_tdata[43:28]))
      else $error("new record has a version range");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == ST_CLEARED || rsp_tuser == ST_FULL))
         |-> (rsp_tdata[48:0] == '0))
      else $error("cleared result carries record data");
`endif

endmodule
